// ===== rtl/core/crc32_with_ines_header_skip_defines.svh =====
// Assertion macros shared by the checker of the header-skipping CRC-32 block.
// Depends on a clock named clock and a reset named reset in the using scope.
`ifndef CRC32_WITH_INES_HEADER_SKIP_DEFINES_SVH
`define CRC32_WITH_INES_HEADER_SKIP_DEFINES_SVH

// Checked only outside reset.
`define CRCIH_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked at every edge, reset included.
`define CRCIH_ASSERT_ALWAYS(name, prop, msg) \
   name: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== rtl/core/crcih_pkg.sv =====
// Types, constants and functions of the header-skipping CRC-32 block.
// Used by every module of the block; depends on nothing.
`default_nettype none

package crcih_pkg;

   localparam int HEADER_BYTES = 16;
   localparam int POS_WIDTH = $clog2(HEADER_BYTES + 1);
   localparam int MAGIC_BYTES = 4;

   localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
   localparam logic [31:0] CRC_ONES = 32'hFFFF_FFFF;

   localparam logic [7:0] MAGIC_0 = 8'h4E;
   localparam logic [7:0] MAGIC_1 = 8'h45;
   localparam logic [7:0] MAGIC_2 = 8'h53;
   localparam logic [7:0] MAGIC_3 = 8'h1A;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_WIDTH = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [31:0] crc_value;
      logic        header_skipped;
   } rsp_type;

   // Classified item passed from the front to the back.
   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
      logic       in_payload;
      logic       skip;
   } cmd_type;

   function automatic logic [7:0] magic_byte(input logic [1:0] idx);
      logic [7:0] value;
      unique case (idx)
         2'd0: value = MAGIC_0;
         2'd1: value = MAGIC_1;
         2'd2: value = MAGIC_2;
         2'd3: value = MAGIC_3;
         default: value = MAGIC_0;
      endcase
      return value;
   endfunction

   // Reflected CRC-32 advanced by one byte; unrolls into an XOR network.
   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] data);
      logic [31:0] c;
      c = crc ^ {24'd0, data};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
      end
      return c;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/crcih_front.sv =====
// Front end: accepts file bytes, tracks the header position and the magic match.
// Depends on crcih_pkg; feeds classified items into crcih_queue.
`default_nettype none

module crcih_front
   import crcih_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_push,
   input  wire req_type req_item,
   input  wire logic    queue_full,
   output logic         queue_push,
   output cmd_type      queue_entry
);

   logic [POS_WIDTH-1:0] pos_ff, pos_in;
   logic                 magic_ff, magic_in;
   logic [POS_WIDTH-1:0] pos_next;
   logic                 magic_next;
   logic                 in_header;
   logic                 mismatch;

   assign queue_push = req_push && !queue_full;

   always_comb begin
      in_header = pos_ff < POS_WIDTH'(HEADER_BYTES);
      mismatch = (pos_ff < POS_WIDTH'(MAGIC_BYTES))
                 && (req_item.data_byte != magic_byte(pos_ff[1:0]));
      pos_next = in_header ? pos_ff + POS_WIDTH'(1) : pos_ff;
      magic_next = magic_ff && !(in_header && mismatch);

      queue_entry.data_byte = req_item.data_byte;
      queue_entry.last_byte = req_item.last_byte;
      queue_entry.in_payload = !in_header;
      queue_entry.skip = magic_next && (pos_next >= POS_WIDTH'(HEADER_BYTES));

      pos_in = pos_ff;
      magic_in = magic_ff;
      if (queue_push) begin
         // The last byte closes the file, so the next byte starts a new one.
         if (req_item.last_byte) begin
            pos_in = '0;
            magic_in = 1'b1;
         end else begin
            pos_in = pos_next;
            magic_in = magic_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         magic_ff <= 1'b1;
      end else begin
         pos_ff <= pos_in;
         magic_ff <= magic_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/crcih_queue.sv =====
// Short queue of classified items between the front and the back.
// Depends on crcih_pkg.
`default_nettype none

module crcih_queue
   import crcih_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire cmd_type entry_in,
   output logic         full,
   input  wire logic    pop,
   output cmd_type      entry_out,
   output logic         empty
);

   cmd_type                    entries_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_WIDTH-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_WIDTH-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_WIDTH-1:0] count_ff, count_in;
   logic                       do_push;
   logic                       do_pop;

   assign full = count_ff == QUEUE_CNT_WIDTH'(QUEUE_DEPTH);
   assign empty = count_ff == '0;
   assign entry_out = entries_ff[rd_ptr_ff];

   always_comb begin
      do_push = push && !full;
      do_pop = pop && !empty;
      wr_ptr_in = do_push ? wr_ptr_ff + QUEUE_PTR_WIDTH'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + QUEUE_PTR_WIDTH'(1) : rd_ptr_ff;
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + QUEUE_CNT_WIDTH'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QUEUE_CNT_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= entry_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/crcih_back.sv =====
// Back end: runs the full and payload CRC registers and holds the result.
// Depends on crcih_pkg; takes classified items from crcih_queue.
`default_nettype none

module crcih_back
   import crcih_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire cmd_type cmd,
   input  wire logic    cmd_empty,
   output logic         cmd_pop,
   input  wire logic    rsp_pop,
   output logic         rsp_empty,
   output rsp_type      rsp_item
);

   logic [31:0] full_crc_ff, full_crc_in;
   logic [31:0] payload_crc_ff, payload_crc_in;
   logic        out_valid_ff, out_valid_in;
   rsp_type     out_item_ff, out_item_in;
   logic [31:0] full_next;
   logic [31:0] payload_next;

   assign rsp_empty = !out_valid_ff;
   assign rsp_item = out_item_ff;

   always_comb begin
      // A last item needs the result register, which frees up when it is popped.
      cmd_pop = !cmd_empty && (!cmd.last_byte || !out_valid_ff || rsp_pop);
      full_next = crc_byte(full_crc_ff, cmd.data_byte);
      payload_next = cmd.in_payload ? crc_byte(payload_crc_ff, cmd.data_byte)
                                    : payload_crc_ff;

      full_crc_in = full_crc_ff;
      payload_crc_in = payload_crc_ff;
      out_item_in = out_item_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      if (cmd_pop) begin
         if (cmd.last_byte) begin
            full_crc_in = CRC_ONES;
            payload_crc_in = CRC_ONES;
            out_valid_in = 1'b1;
            out_item_in.crc_value = (cmd.skip ? payload_next : full_next) ^ CRC_ONES;
            out_item_in.header_skipped = cmd.skip;
         end else begin
            full_crc_in = full_next;
            payload_crc_in = payload_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      out_item_ff <= out_item_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         full_crc_ff <= CRC_ONES;
         payload_crc_ff <= CRC_ONES;
         out_valid_ff <= 1'b0;
      end else begin
         full_crc_ff <= full_crc_in;
         payload_crc_ff <= payload_crc_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/crc32_with_ines_header_skip.sv =====
// A last byte is registered in the queue first, then its result in the result register.
// Throughput: one byte per cycle unless full; the back end's byte-wide CRC update sets it.
// The four-entry queue absorbs stalls of the result side before full is raised.
// Reset (synchronous, active high) empties the queue and the result register and restores
// the CRC registers to all ones, the header position to zero and the magic match to one.
`default_nettype none

module crc32_with_ines_header_skip
   import crcih_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_push,
   input  wire req_type req_item,
   output logic         req_full,
   input  wire logic    rsp_pop,
   output logic         rsp_empty,
   output rsp_type      rsp_item
);

   logic    queue_push;
   cmd_type queue_entry;
   logic    queue_pop;
   logic    queue_empty;
   cmd_type queue_head;

   crcih_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_item    (req_item),
      .queue_full  (req_full),
      .queue_push  (queue_push),
      .queue_entry (queue_entry)
   );

   crcih_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (queue_push),
      .entry_in  (queue_entry),
      .full      (req_full),
      .pop       (queue_pop),
      .entry_out (queue_head),
      .empty     (queue_empty)
   );

   crcih_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd       (queue_head),
      .cmd_empty (queue_empty),
      .cmd_pop   (queue_pop),
      .rsp_pop   (rsp_pop),
      .rsp_empty (rsp_empty),
      .rsp_item  (rsp_item)
   );

endmodule

`default_nettype wire

// ===== rtl/core/crcih_checker.sv =====
// Port-level checks of the header-skipping CRC-32 block, bound to its top level.
// Depends on crcih_pkg and crc32_with_ines_header_skip_defines.svh.
`default_nettype none
`include "crc32_with_ines_header_skip_defines.svh"

module crcih_checker
   import crcih_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_push,
   input wire req_type req_item,
   input wire logic    req_full,
   input wire logic    rsp_pop,
   input wire logic    rsp_empty,
   input wire rsp_type rsp_item
);

   // After reset no result is pending and the input side has room.
   `CRCIH_ASSERT_ALWAYS(a_reset_rsp_empty, reset |=> rsp_empty, "result present after reset")
   `CRCIH_ASSERT_ALWAYS(a_reset_not_full, reset |=> !req_full, "input full after reset")

   // A waiting result that is not popped stays and does not change.
   `CRCIH_ASSERT(a_rsp_hold, (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_item)), "result changed while stalled")

endmodule

bind crc32_with_ines_header_skip crcih_checker u_checker (.*);

`default_nettype wire
